@@ rtl/cacfar_pkg.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR detector package
// Shared widths, reset constants and pipeline payload types.
// ----------------------------------------------------------------------------
package cacfar_pkg;

  localparam int DATA_W = 16;   // Q8.8 sample width
  localparam int FRAC_W = 8;    // fractional bits of Q8.8
  localparam int KEEP_W = 2;    // one keep/strobe bit per data byte

  localparam logic [DATA_W-1:0] ALPHA_RESET = 16'd256;  // 1.0 in Q8.8

  // Stream sideband, always taken from the newest input.
  typedef struct packed {
    logic              last;
    logic [KEEP_W-1:0] keep;
    logic [KEEP_W-1:0] strobe;
  } side_t;

  // Per-stage payload that rides along the threshold pipeline.
  typedef struct packed {
    logic signed [DATA_W-1:0] centre;
    side_t                    side;
  } stage_t;

endpackage

@@ rtl/cacfar_in_if.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR sample channel
// Valid/ready channel carrying one input sample and its stream sideband.
// ----------------------------------------------------------------------------
interface cacfar_in_if
  import cacfar_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_value;
  logic                     frame_last;
  logic [KEEP_W-1:0]        byte_keep;
  logic [KEEP_W-1:0]        byte_strobe;

  modport source (
    output valid, sample_value, frame_last, byte_keep, byte_strobe,
    input  ready
  );

  modport sink (
    input  valid, sample_value, frame_last, byte_keep, byte_strobe,
    output ready
  );
endinterface

@@ rtl/cacfar_out_if.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR detection channel
// Valid/ready channel carrying one detection result and its sideband.
// ----------------------------------------------------------------------------
interface cacfar_out_if
  import cacfar_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] detect_value;
  logic                     out_last;
  logic [KEEP_W-1:0]        out_keep;
  logic [KEEP_W-1:0]        out_strobe;

  modport source (
    output valid, detect_value, out_last, out_keep, out_strobe,
    input  ready
  );

  modport sink (
    input  valid, detect_value, out_last, out_keep, out_strobe,
    output ready
  );
endinterface

@@ rtl/cacfar_cfg_if.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR configuration channel
// Valid/ready write channel for the threshold gain register.
// ----------------------------------------------------------------------------
interface cacfar_cfg_if
  import cacfar_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] alpha_gain;

  modport source (
    output valid, alpha_gain,
    input  ready
  );

  modport sink (
    input  valid, alpha_gain,
    output ready
  );
endinterface

@@ rtl/ca_cfar_detector_core.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR detector core
// Cell-averaging CFAR over a sliding window of Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage:
//   samp_i carries one Q8.8 sample plus last/keep/strobe per transaction.
//   det_o returns exactly one transaction per accepted sample: the centre
//   cell if it is strictly above alpha_gain times the reference average,
//   else zero, with last/keep/strobe of the newest sample (not the centre).
//   cfg_i writes alpha_gain (unsigned Q8.8); it is always ready and must
//   only be written while the pipeline is drained.
// Throughput: one sample per clock, sustained, while det_o is taken.
// Pipeline: a result is registered on det_o after passing the stages window,
//   sum, reciprocal multiply, gain multiply and output register.
// Stalls: every stage advances when it is empty or its successor advances,
//   so bubbles collapse; samp_i.ready drops only when all stages are full
//   and det_o is stalled.
// Reset: all window cells and running sums clear to zero, alpha_gain goes
//   to 1.0, the pipeline empties. There is no fill tracking: zero cells
//   from reset take part in the average until the window has filled.
// ----------------------------------------------------------------------------
module ca_cfar_detector_core
  import cacfar_pkg::*;
#(
  parameter int REF_COUNT   = 8,
  parameter int GUARD_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cacfar_in_if.sink   samp_i,
  cacfar_out_if.source det_o,
  cacfar_cfg_if.sink  cfg_i
);

  localparam int CUT_POS = REF_COUNT + GUARD_COUNT;
  localparam int WIN_LEN = 2 * CUT_POS + 1;
  localparam int DIV     = 2 * REF_COUNT;
  localparam int LOG_D   = $clog2(DIV);
  localparam int SUM_W   = DATA_W + LOG_D;
  localparam int NUM_W   = SUM_W + 1;

  // Offset DIV*BIAS >= 2**(SUM_W-1) keeps the numerator non-negative.
  localparam longint unsigned BIAS_FULL =
    ((64'd1 << (SUM_W - 1)) + DIV - 1) / DIV;
  localparam logic [NUM_W-1:0] SUM_OFFSET = NUM_W'(BIAS_FULL * DIV);

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic en_s1, en_s2, en_s3, en_s4, en_out;
  logic vld_s1_q, vld_s2_q, vld_s3_q, vld_s4_q, vld_out_q;
  logic accept;

  assign en_out = !vld_out_q || det_o.ready;
  assign en_s4  = !vld_s4_q  || en_out;
  assign en_s3  = !vld_s3_q  || en_s4;
  assign en_s2  = !vld_s2_q  || en_s3;
  assign en_s1  = !vld_s1_q  || en_s2;

  assign samp_i.ready = en_s1;
  assign accept       = samp_i.valid && en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s1_q  <= 1'b0;
      vld_s2_q  <= 1'b0;
      vld_s3_q  <= 1'b0;
      vld_s4_q  <= 1'b0;
      vld_out_q <= 1'b0;
    end else begin
      if (en_s1)  vld_s1_q  <= samp_i.valid;
      if (en_s2)  vld_s2_q  <= vld_s1_q;
      if (en_s3)  vld_s3_q  <= vld_s2_q;
      if (en_s4)  vld_s4_q  <= vld_s3_q;
      if (en_out) vld_out_q <= vld_s4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration: single gain register, written whenever cfg_i is valid.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] alpha_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else if (cfg_i.valid) begin
      alpha_q <= cfg_i.alpha_gain;
    end
  end

  // --------------------------------------------------------------------------
  // Window: chain of cells, cell 0 newest, shifting on every accept.
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] win [WIN_LEN];

  for (genvar gi = 0; gi < WIN_LEN; gi++) begin : g_win
    logic signed [DATA_W-1:0] cell_d;
    if (gi == 0) begin : g_head
      assign cell_d = samp_i.sample_value;
    end else begin : g_link
      assign cell_d = win[gi-1];
    end
    cacfar_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .d_i     (cell_d),
      .q_o     (win[gi])
    );
  end

  // Running sums of the leading and trailing reference cells. On a shift the
  // leading group gains the new sample and loses the cell that moves into the
  // guard band; the trailing group gains the cell leaving the guard band and
  // loses the oldest cell.
  logic signed [SUM_W-1:0] lead_q, lead_d;
  logic signed [SUM_W-1:0] trail_q, trail_d;

  always_comb begin
    lead_d  = lead_q  + SUM_W'(samp_i.sample_value) - SUM_W'(win[REF_COUNT-1]);
    trail_d = trail_q + SUM_W'(win[CUT_POS+GUARD_COUNT]) - SUM_W'(win[WIN_LEN-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= '0;
      trail_q <= '0;
    end else if (accept) begin
      lead_q  <= lead_d;
      trail_q <= trail_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: hold centre and sideband; sums stay put while this stage is full
  // because no new sample is accepted until it moves on.
  // --------------------------------------------------------------------------
  stage_t s1_q, s2_q, s3_q, s4_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.centre      <= win[CUT_POS-1];
      s1_q.side.last   <= samp_i.frame_last;
      s1_q.side.keep   <= samp_i.byte_keep;
      s1_q.side.strobe <= samp_i.byte_strobe;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: total reference sum plus offset, unsigned numerator.
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en_s2) begin
      num_q <= NUM_W'(lead_q) + NUM_W'(trail_q) + SUM_OFFSET;
      s2_q  <= s1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: reciprocal multiply inside the averager.
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] noise;

  cacfar_div #(
    .REF_COUNT (REF_COUNT)
  ) u_div (
    .clk_i   (clk_i),
    .en_i    (en_s3),
    .num_i   (num_q),
    .noise_o (noise)
  );

  always_ff @(posedge clk_i) begin
    if (en_s3) begin
      s3_q <= s2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: threshold = floor(noise * alpha / 256), wrapped to 16 bits.
  // --------------------------------------------------------------------------
  logic signed [2*DATA_W:0] thr_prod;
  logic signed [DATA_W-1:0] thr_q;

  assign thr_prod = noise * $signed({1'b0, alpha_q});

  always_ff @(posedge clk_i) begin
    if (en_s4) begin
      thr_q <= $signed(thr_prod[FRAC_W+DATA_W-1:FRAC_W]);
      s4_q  <= s3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pass the centre only when strictly above threshold.
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] det_q;
  side_t                    side_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      det_q  <= (s4_q.centre > thr_q) ? s4_q.centre : '0;
      side_q <= s4_q.side;
    end
  end

  assign det_o.valid        = vld_out_q;
  assign det_o.detect_value = det_q;
  assign det_o.out_last     = side_q.last;
  assign det_o.out_keep     = side_q.keep;
  assign det_o.out_strobe   = side_q.strobe;

endmodule

@@ rtl/cacfar_cell.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR window cell
// One sample slot of the delay line; takes its neighbor's sample on shift.
// ----------------------------------------------------------------------------
module cacfar_cell
  import cacfar_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic signed [DATA_W-1:0] d_i,
  output logic signed [DATA_W-1:0] q_o
);

  logic signed [DATA_W-1:0] sample_q;
  logic signed [DATA_W-1:0] sample_d;

  always_comb begin
    sample_d = shift_i ? d_i : sample_q;
  end

  // The window is part of the detector state, so clear it at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign q_o = sample_q;

endmodule

@@ rtl/cacfar_div.sv @@
// ----------------------------------------------------------------------------
// CA-CFAR noise averager
// Floor division of the offset reference sum by 2*REF_COUNT via reciprocal.
// ----------------------------------------------------------------------------
module cacfar_div
  import cacfar_pkg::*;
#(
  parameter int REF_COUNT = 8
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [DATA_W+$clog2(2*REF_COUNT):0] num_i,
  output logic signed [DATA_W-1:0]          noise_o
);

  localparam int DIV   = 2 * REF_COUNT;
  localparam int LOG_D = $clog2(DIV);
  localparam int NUM_W = DATA_W + LOG_D + 1;
  localparam int SHIFT = NUM_W + LOG_D;
  localparam int MUL_W = NUM_W + 1;
  localparam int PRD_W = NUM_W + MUL_W;

  // Reciprocal rounded up; exact for every numerator below 2**NUM_W.
  localparam longint unsigned RECIP_FULL = ((64'd1 << SHIFT) + DIV - 1) / DIV;
  // Bias that the caller added (as DIV*BIAS) to make the sum non-negative.
  localparam longint unsigned BIAS_FULL  =
    ((64'd1 << (DATA_W - 1 + LOG_D)) + DIV - 1) / DIV;

  localparam logic [MUL_W-1:0]  RECIP = RECIP_FULL[MUL_W-1:0];
  localparam logic [DATA_W-1:0] BIAS  = BIAS_FULL[DATA_W-1:0];

  logic [PRD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {{MUL_W{1'b0}}, num_i} * {{NUM_W{1'b0}}, RECIP};
    end
  end

  // Drop the bias; the average always fits Q8.8, so 16 bits suffice.
  assign noise_o = $signed(prod_q[SHIFT+DATA_W-1:SHIFT] - BIAS);

endmodule

@@ tb/ca_cfar_detector_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CA-CFAR detector checker
// Watches the sample, detection and gain channels, predicts every detection
// from its own copy of the window and gain, and compares field by field.
// ----------------------------------------------------------------------------
module ca_cfar_detector_checker
  import cacfar_pkg::*;
#(
  parameter int REF_COUNT   = 8,
  parameter int GUARD_COUNT = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cacfar_in_if  samp,
  cacfar_out_if det,
  cacfar_cfg_if cfg,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int CUT_POS = REF_COUNT + GUARD_COUNT;
  localparam int WIN_LEN = 2 * CUT_POS + 1;
  localparam int AVG_LEN = 2 * REF_COUNT;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    side_t                    side;
  } detection_t;

  logic signed [DATA_W-1:0] window_q [WIN_LEN];
  logic [DATA_W-1:0]        gain_q;
  detection_t               pending_detections [$];

  wire samp_fire = samp.valid && samp.ready;
  wire det_fire  = det.valid && det.ready;
  wire cfg_fire  = cfg.valid && cfg.ready;

  // Shift the new sample in and work out the detection it causes.
  task automatic predict_detection(input logic signed [DATA_W-1:0] sample,
                                   input side_t side);
    longint                   acc;
    longint                   level;
    longint                   scaled;
    int                       span;
    logic signed [DATA_W-1:0] noise;
    logic signed [DATA_W-1:0] thresh;
    detection_t               det_exp;
    for (int i = WIN_LEN - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = sample;
    acc = 0;
    for (int i = 0; i < WIN_LEN; i++) begin
      span = (i > CUT_POS) ? i - CUT_POS : CUT_POS - i;
      if (span > GUARD_COUNT) acc += window_q[i];
    end
    // floor division by the reference cell count
    level = acc / AVG_LEN;
    if (acc < 0 && (acc % AVG_LEN) != 0) level -= 1;
    noise  = level[DATA_W-1:0];
    scaled = (longint'(noise) * longint'(gain_q)) >>> FRAC_W;
    thresh = scaled[DATA_W-1:0];
    det_exp.value = (window_q[CUT_POS] > thresh) ? window_q[CUT_POS] : '0;
    det_exp.side  = side;
    pending_detections.push_back(det_exp);
  endtask

  task automatic check_detection();
    detection_t det_exp;
    if (pending_detections.size() == 0) begin
      $display("%0t: unexpected detection transaction, value %h", $time,
               det.detect_value);
      fail_count_o++;
    end else begin
      det_exp = pending_detections.pop_front();
      if (det.detect_value !== det_exp.value) begin
        $display("%0t: detect_value expected %h, actual %h", $time,
                 det_exp.value, det.detect_value);
        fail_count_o++;
      end
      if (det.out_last !== det_exp.side.last) begin
        $display("%0t: out_last expected %b, actual %b", $time,
                 det_exp.side.last, det.out_last);
        fail_count_o++;
      end
      if (det.out_keep !== det_exp.side.keep) begin
        $display("%0t: out_keep expected %b, actual %b", $time,
                 det_exp.side.keep, det.out_keep);
        fail_count_o++;
      end
      if (det.out_strobe !== det_exp.side.strobe) begin
        $display("%0t: out_strobe expected %b, actual %b", $time,
                 det_exp.side.strobe, det.out_strobe);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) window_q[i] = '0;
      gain_q = ALPHA_RESET;
      pending_detections.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_fire) gain_q = cfg.alpha_gain;
      if (samp_fire) begin
        predict_detection(samp.sample_value,
                          '{last: samp.frame_last, keep: samp.byte_keep,
                            strobe: samp.byte_strobe});
      end
      if (det_fire) check_detection();
      pending_o <= pending_o + int'(samp_fire) - int'(det_fire);
    end
  end

endmodule

@@ tb/ca_cfar_detector_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CA-CFAR detector core test
// Drives samples in bursts with random gaps against a stalling receiver,
// steps the threshold gain through several settings between drained phases,
// and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module ca_cfar_detector_core_test;
  import cacfar_pkg::*;

  localparam int REF_COUNT   = 8;
  localparam int GUARD_COUNT = 2;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 103;
  localparam int IDLE_LIMIT  = 5000;   // cycles without any transaction
  localparam int DRAIN_TAIL  = 8;      // idle tail after the drain

  // Receiver behavior, switched every stretch of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_RANDOM,    // ready at random, with probability 3/4
    RX_PACED,     // ready a quarter of the time, regular
    RX_STARVED    // ready rarely, long stalls
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_stretch = 0;

  cacfar_in_if  samp ();
  cacfar_out_if det ();
  cacfar_cfg_if cfg ();

  ca_cfar_detector_core #(
    .REF_COUNT   (REF_COUNT),
    .GUARD_COUNT (GUARD_COUNT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp),
    .det_o  (det),
    .cfg_i  (cfg)
  );

  ca_cfar_detector_checker #(
    .REF_COUNT   (REF_COUNT),
    .GUARD_COUNT (GUARD_COUNT)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .samp         (samp),
    .det          (det),
    .cfg          (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver: pick a new stall mode every stretch, drive ready at the edge.
  always @(posedge clk_i) begin
    if (rx_stretch == 0) begin
      rx_mode    <= rx_mode_e'($urandom_range(0, 3));
      rx_stretch <= $urandom_range(20, 200);
    end else begin
      rx_stretch <= rx_stretch - 1;
    end
    case (rx_mode)
      RX_OPEN:    det.ready <= 1'b1;
      RX_RANDOM:  det.ready <= ($urandom_range(0, 3) != 0);
      RX_PACED:   det.ready <= (rx_stretch % 4 == 0);
      RX_STARVED: det.ready <= ($urandom_range(0, 15) == 0);
      default:    det.ready <= 1'b1;
    endcase
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((samp.valid && samp.ready) || (det.valid && det.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample and hold it until the transaction completes. Valid stays
  // high on return so back-to-back samples never drop it.
  task automatic push_sample(input logic [DATA_W-1:0] value, input logic last,
                             input logic [KEEP_W-1:0] keep,
                             input logic [KEEP_W-1:0] strobe);
    samp.valid        <= 1'b1;
    samp.sample_value <= value;
    samp.frame_last   <= last;
    samp.byte_keep    <= keep;
    samp.byte_strobe  <= strobe;
    do @(posedge clk_i); while (!samp.ready);
  endtask

  // Drop valid for a gap of length n; a zero gap keeps the burst going.
  task automatic hold_off(input int n);
    if (n > 0) begin
      samp.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Wait until every predicted detection has come out. The first edge lets
  // the checker's count catch up with the last sample transaction.
  task automatic drain_results();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Gain writes only go in with the pipeline empty.
  task automatic write_gain(input logic [DATA_W-1:0] gain);
    samp.valid <= 1'b0;
    drain_results();
    cfg.valid      <= 1'b1;
    cfg.alpha_gain <= gain;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Radar-like sample: mostly noise around a floor, some strong targets, the
  // rest anywhere in the signed range. Clamp to Q8.8.
  function automatic logic [DATA_W-1:0] draw_sample(input int floor_level,
                                                    input int spread);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      v = floor_level + int'($urandom_range(0, 2 * spread)) - spread;
    end else if (pick < 80) begin
      v = int'($urandom_range(16'h4000, 16'h7FFF));
    end else begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[DATA_W-1:0];
  endfunction

  // Directed samples: range extremes first, then a quiet floor, a target in
  // it, and the extremes again inside a filled window.
  localparam int DIRECTED = 24;
  localparam logic [DATA_W-1:0] DIRECTED_SAMPLES [DIRECTED] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
    16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010,
    16'h0010, 16'h0010, 16'h0010, 16'h0010, 16'h0010,
    16'h7000, 16'h0010, 16'h0010, 16'h0010, 16'h0010,
    16'h0010, 16'h8000, 16'h7FFF, 16'h0100
  };

  initial begin
    int          floor_level;
    int          spread;
    int          burst_left;
    bit          steady;
    logic [15:0] gain;

    rst_ni            <= 1'b0;
    samp.valid        <= 1'b0;
    samp.sample_value <= '0;
    samp.frame_last   <= 1'b0;
    samp.byte_keep    <= '0;
    samp.byte_strobe  <= '0;
    cfg.valid         <= 1'b0;
    cfg.alpha_gain    <= '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset gain of 1.0. The window is still filling with
    // zeros from reset, and frame markers land before the centre cells get out.
    for (int i = 0; i < DIRECTED; i++) begin
      push_sample(DIRECTED_SAMPLES[i], (i % 7 == 6) || (i == DIRECTED - 1),
                  KEEP_W'(i % 4), KEEP_W'((i / 4) % 4));
    end

    // Random phases, one gain setting each. The first drives a large noise
    // floor into full gain so the threshold product wraps negative; the next
    // sets a zero gain; others cover small, random and mid-scale gains.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin gain = 16'hFFFF; floor_level = 16'h6000;  spread = 16'h1000; end
        1: begin gain = 16'h0000; floor_level = 0;         spread = 16'h0400; end
        2: begin gain = 16'h0100; floor_level = 16'h0200;  spread = 16'h0080; end
        3: begin gain = 16'h0300; floor_level = 16'h0400;  spread = 16'h0200; end
        5: begin gain = 16'h0001; floor_level = -16'sh2000; spread = 16'h0800; end
        7: begin gain = 16'h8000; floor_level = 16'h0100;  spread = 16'h0100; end
        default: begin
          gain        = 16'($urandom_range(0, 65535));
          floor_level = int'($urandom_range(0, 65535)) - 32768;
          spread      = $urandom_range(0, 16'h2000);
        end
      endcase
      write_gain(gain);

      // Every third phase streams without sender gaps.
      steady     = (phase % 3 == 0);
      burst_left = $urandom_range(1, 60);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          hold_off(steady ? 0 : $urandom_range(0, 30));
          burst_left = $urandom_range(1, 60);
        end
        push_sample(draw_sample(floor_level, spread), ($urandom_range(0, 31) == 0),
                    KEEP_W'($urandom_range(0, 3)), KEEP_W'($urandom_range(0, 3)));
        burst_left--;
      end
    end

    // Drain, wait out the idle tail, then report.
    samp.valid <= 1'b0;
    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
